@@ design/plom_pkg.sv @@
// Package for the ping latency overload monitor: sizes, codes, controller states.
// No dependencies.
package plom_pkg;

    localparam int NUM_BUCKETS   = 128;
    localparam int HISTORY_DEPTH = 128;
    localparam int BIDX_W = $clog2(NUM_BUCKETS);
    localparam int HIDX_W = $clog2(HISTORY_DEPTH);
    localparam int BCNT_W = $clog2(NUM_BUCKETS + 1);
    localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
    // weighted sum: 32-bit counts times the sum of 1..NUM_BUCKETS
    localparam int SUM_W  = 32 + $clog2(NUM_BUCKETS * (NUM_BUCKETS + 1) / 2 + 1);
    localparam int ENT_W  = 32 + BCNT_W;
    // clearing pass after reset covers the deeper of the two RAMs
    localparam int CLR_DEPTH = (NUM_BUCKETS > HISTORY_DEPTH) ? NUM_BUCKETS : HISTORY_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [23:0] LAT_MAX = 24'hFFFFFF;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_RESP    = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;
    localparam logic [1:0] KIND_RSVD    = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_NBUCK  = 3'd1;
    localparam logic [2:0] REG_THRESH = 3'd2;
    localparam logic [2:0] REG_HLEN   = 3'd3;
    localparam logic [2:0] REG_CLRWIN = 3'd4;
    localparam logic [2:0] REG_EXCWIN = 3'd5;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_RESP_RD,
        ST_RESP_WR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_MEAN,
        ST_LAT,
        ST_WIN_RD,
        ST_WIN,
        ST_HEAD,
        ST_OUT
    } plom_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic clear;       // zero one entry of each RAM
        logic load;        // capture input transaction
        logic div_step;    // one quotient bit
        logic resp_rd;     // issue bucket read for response
        logic resp_wr;     // write incremented bucket
        logic scan_rd;     // issue scan read at scan index, zeroing that bucket
        logic scan_acc;    // accumulate returned scan data
        logic mean_step;   // one mean quotient bit
        logic lat_wr;      // compute latency and write history
        logic win_rd;      // issue window read
        logic win_acc;     // accumulate window entry
        logic head_step;   // wrap history head by the history length
        logic finish;      // build result
    } plom_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] kind;
        logic       clr_done;
        logic       resp_ok;
        logic       div_done;
        logic       scan_last;
        logic       mean_done;
        logic       win_last;
        logic       head_ok;
    } plom_stat_t;

endpackage

@@ design/plom_if.sv @@
// Valid/ready channel interface for the monitor.
// Depends on nothing; payload carried as plain signals, without parameters.
interface plom_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] now_time;
    logic [31:0] ping_time;
    logic [31:0] ping_seq;
    modport source (output valid, kind, now_time, ping_time, ping_seq, input ready);
    modport sink (input valid, kind, now_time, ping_time, ping_seq, output ready);
endinterface

interface plom_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_out;
    logic        accepted;
    logic        overloaded;
    logic [23:0] latency_ms;
    logic [7:0]  clear_count;
    logic [7:0]  exceed_count;
    modport source (output valid, seq_out, accepted, overloaded, latency_ms, clear_count,
                    exceed_count, input ready);
    modport sink (input valid, seq_out, accepted, overloaded, latency_ms, clear_count,
                  exceed_count, output ready);
endinterface

@@ design/plom_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module plom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/plom_ctrl.sv @@
// Controller state machine of the monitor.
// Depends on plom_pkg.
module plom_ctrl
    import plom_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  plom_stat_t stat,
    output plom_cmd_t  cmd
);
    plom_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:       if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid && !ovalid_reg)
                begin
                    priority case (stat.kind)
                        KIND_RESP:    state_next = ST_DIV;
                        KIND_COMPUTE: state_next = ST_SCAN;
                        default:      state_next = ST_OUT;
                    endcase
                end
            end
            ST_DIV:       if (stat.div_done) state_next = stat.resp_ok ? ST_RESP_RD : ST_OUT;
            ST_RESP_RD:   state_next = ST_RESP_WR;
            ST_RESP_WR:   state_next = ST_OUT;
            ST_SCAN:      if (stat.scan_last) state_next = ST_SCAN_LAST;
            ST_SCAN_LAST: state_next = ST_MEAN;
            ST_MEAN:      if (stat.mean_done) state_next = ST_LAT;
            ST_LAT:       state_next = ST_WIN_RD;
            ST_WIN_RD:    state_next = ST_WIN;
            ST_WIN:       if (stat.win_last) state_next = ST_HEAD;
            ST_HEAD:      if (stat.head_ok) state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        ovalid_next = ovalid_reg && !out_ready;
        in_ready = (state_reg == ST_IDLE) && !ovalid_reg;
        unique case (state_reg)
            ST_CLR:       cmd.clear = 1'b1;
            ST_IDLE:      cmd.load = in_valid && !ovalid_reg;
            ST_DIV:       cmd.div_step = 1'b1;
            ST_RESP_RD:   cmd.resp_rd = 1'b1;
            ST_RESP_WR:   cmd.resp_wr = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.scan_acc = 1'b1;
            end
            ST_SCAN_LAST: cmd.scan_acc = 1'b1;
            ST_MEAN:      cmd.mean_step = 1'b1;
            ST_LAT:       cmd.lat_wr = 1'b1;
            ST_WIN_RD:    cmd.win_rd = 1'b1;
            ST_WIN:
            begin
                cmd.win_rd  = 1'b1;
                cmd.win_acc = 1'b1;
            end
            ST_HEAD:      cmd.head_step = 1'b1;
            ST_OUT:
            begin
                cmd.finish  = 1'b1;
                ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

@@ design/plom_dp.sv @@
// Datapath of the monitor: sequence state, divider, bucket and history RAMs.
// Depends on plom_pkg and plom_ram.
module plom_dp
    import plom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  plom_cmd_t   cmd,
    output plom_stat_t  stat,
    input  logic [1:0]  kind,
    input  logic [31:0] now_time,
    input  logic [31:0] ping_time,
    input  logic [31:0] ping_seq,
    input  logic [15:0] cfg_width,
    input  logic [7:0]  cfg_nbuck,
    input  logic [23:0] cfg_thresh,
    input  logic [7:0]  cfg_hlen,
    input  logic [7:0]  cfg_clrwin,
    input  logic [7:0]  cfg_excwin,
    output logic [31:0] seq_out,
    output logic        accepted,
    output logic        overloaded,
    output logic [23:0] latency_ms,
    output logic [7:0]  clear_count,
    output logic [7:0]  exceed_count
);
    // architectural state
    logic [31:0]       next_seq_reg, start_seq_reg;
    logic [HCNT_W-1:0] head_reg;
    logic              ovl_reg, ovl_next;
    logic [CLR_W-1:0]  clr_idx_reg;

    // effective configuration
    logic [15:0]       eff_w;
    logic [BCNT_W-1:0] eff_nb;
    logic [HCNT_W-1:0] eff_len;
    logic [7:0]        win_sel;
    logic [HCNT_W-1:0] eff_win;

    assign eff_w  = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
    assign eff_nb = (cfg_nbuck == 8'd0) ? BCNT_W'(1)
                  : (32'(cfg_nbuck) > NUM_BUCKETS) ? BCNT_W'(NUM_BUCKETS)
                  : BCNT_W'(cfg_nbuck);
    assign eff_len = (cfg_hlen == 8'd0) ? HCNT_W'(1)
                   : (32'(cfg_hlen) > HISTORY_DEPTH) ? HCNT_W'(HISTORY_DEPTH)
                   : HCNT_W'(cfg_hlen);
    assign win_sel = ovl_reg ? cfg_clrwin : cfg_excwin;
    assign eff_win = (win_sel == 8'd0 || 32'(win_sel) > 32'(eff_len)) ? eff_len
                   : HCNT_W'(win_sel);

    // captured transaction
    logic [1:0]  kind_reg;
    logic [31:0] seq_in_reg;
    logic        resp_ok_reg;

    // shared restoring divider (32-bit numerator, 16-bit divisor, or mean)
    logic [63:0] num_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [31:0] quot_reg;

    // scan and window
    logic [BCNT_W-1:0] sidx_reg;
    logic              sidx_v_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [23:0]       lat_reg;
    logic [HIDX_W-1:0] wpos_reg;
    logic [HCNT_W-1:0] wcnt_reg;
    logic [HCNT_W-1:0] cl_reg, ex_reg;
    logic              wv_reg;

    // result registers
    logic [31:0] seq_out_reg;
    logic        acc_reg;
    logic [23:0] lat_out_reg;
    logic [7:0]  clr_out_reg, exc_out_reg;

    // latency = mean * width, saturated
    logic [47:0] lat_prod;
    logic [23:0] lat_sat;
    assign lat_prod = 48'(quot_reg) * 48'(eff_w);
    assign lat_sat  = (lat_prod > 48'(LAT_MAX)) ? LAT_MAX : lat_prod[23:0];

    // bucket RAM
    logic              b_we;
    logic [BIDX_W-1:0] b_addr;
    logic [31:0]       b_wdata, b_rdata;
    plom_ram #(.WIDTH(32), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
        .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
    );

    // history RAM
    logic              h_we;
    logic [HIDX_W-1:0] h_addr;
    logic [23:0]       h_wdata;
    logic [23:0]       h_rdata;
    plom_ram #(.WIDTH(24), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
    );

    // bucket index after clamp
    logic [BIDX_W-1:0] bidx;
    assign bidx = (quot_reg >= 32'(eff_nb)) ? BIDX_W'(eff_nb - BCNT_W'(1))
                : BIDX_W'(quot_reg);

    always_comb
    begin
        b_we    = 1'b0;
        b_addr  = bidx;
        b_wdata = (b_rdata == 32'hFFFFFFFF) ? b_rdata : b_rdata + 32'd1;
        if (cmd.clear)
        begin
            b_addr  = BIDX_W'(clr_idx_reg);
            b_we    = 1'b1;
            b_wdata = '0;
        end
        else if (cmd.scan_rd)
        begin
            b_addr  = BIDX_W'(sidx_reg);
            b_we    = 1'b1;
            b_wdata = '0;
        end
        else if (cmd.resp_wr)
        begin
            b_we = 1'b1;
        end
    end

    // history head and window stepping
    logic [HIDX_W-1:0] wpos_prev;
    assign wpos_prev = (wpos_reg == '0) ? HIDX_W'(eff_len - HCNT_W'(1)) : wpos_reg - 1'b1;
    assign h_we    = cmd.clear || cmd.lat_wr;
    assign h_addr  = cmd.clear ? HIDX_W'(clr_idx_reg)
                   : cmd.lat_wr ? HIDX_W'(head_reg) : wpos_reg;
    assign h_wdata = cmd.clear ? 24'd0 : lat_sat;

    // divider step
    logic [SUM_W:0] trial;
    logic [SUM_W-1:0] rem_sh;
    logic [30:0] quot_hi;
    assign rem_sh = {rem_reg[SUM_W-2:0], num_reg[63]};
    assign trial  = {1'b0, rem_sh}
                  - {1'b0, (kind_reg == KIND_RESP) ? SUM_W'(eff_w) : SUM_W'(ent_reg)};
    // first mean step drops the preset quotient used for an empty histogram
    assign quot_hi = (cmd.mean_step && dcnt_reg == 6'(64 - SUM_W)) ? 31'd0 : quot_reg[30:0];

    assign stat.kind      = kind;
    assign stat.clr_done  = (clr_idx_reg == CLR_W'(CLR_DEPTH - 1));
    assign stat.resp_ok   = resp_ok_reg;
    assign stat.div_done  = (dcnt_reg == 6'd31);
    assign stat.scan_last = (sidx_reg == eff_nb - BCNT_W'(1));
    assign stat.mean_done = (dcnt_reg == 6'd63) || (ent_reg == '0);
    assign stat.win_last  = wv_reg && (wcnt_reg == eff_win - HCNT_W'(1));
    assign stat.head_ok   = (head_reg < eff_len);

    always_comb
    begin
        ovl_next = ovl_reg;
        if (ovl_reg)
        begin
            if (ex_reg == '0) ovl_next = 1'b0;
        end
        else if (ex_reg != '0 && cl_reg == '0)
        begin
            ovl_next = 1'b1;
        end
    end

    // control-state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg  <= '0;
            start_seq_reg <= '0;
            head_reg      <= '0;
            ovl_reg       <= 1'b0;
            clr_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clear) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.load && kind == KIND_SEND) next_seq_reg <= next_seq_reg + 32'd1;
            if (cmd.lat_wr)
            begin
                start_seq_reg <= next_seq_reg;
                head_reg      <= head_reg + 1'b1;
            end
            // head modulo history length, one subtraction per cycle
            if (cmd.head_step && head_reg >= eff_len) head_reg <= head_reg - eff_len;
            if (cmd.finish && kind_reg == KIND_COMPUTE) ovl_reg <= ovl_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            seq_in_reg  <= next_seq_reg;
            resp_ok_reg <= (now_time >= ping_time) && (ping_seq >= start_seq_reg)
                           && (ping_seq < next_seq_reg);
            num_reg     <= {now_time - ping_time, 32'd0};
            rem_reg     <= '0;
            dcnt_reg    <= '0;
            quot_reg    <= '0;
            sidx_reg    <= '0;
            sidx_v_reg  <= 1'b0;
            sum_reg     <= '0;
            ent_reg     <= '0;
        end
        if (cmd.div_step || (cmd.mean_step && ent_reg != '0))
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            num_reg  <= {num_reg[62:0], 1'b0};
            if (!trial[SUM_W])
            begin
                rem_reg  <= trial[SUM_W-1:0];
                quot_reg <= {quot_hi, 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                quot_reg <= {quot_hi, 1'b0};
            end
        end
        if (cmd.scan_rd)
        begin
            sidx_reg   <= sidx_reg + BCNT_W'(1);
            sidx_v_reg <= 1'b1;
        end
        if (cmd.scan_acc && sidx_v_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(64'(b_rdata) * 64'(sidx_reg));
            ent_reg <= ent_reg + ENT_W'(b_rdata);
        end
        if (cmd.scan_acc && !cmd.scan_rd)
        begin
            // mean division setup: numerator is sum, left aligned in 64 bits
            num_reg  <= 64'(sum_reg + SUM_W'(64'(b_rdata) * 64'(sidx_reg)))
                        << (64 - SUM_W);
            dcnt_reg <= 6'(64 - SUM_W);
            rem_reg  <= '0;
            quot_reg <= 32'd1;
        end
        if (cmd.lat_wr)
        begin
            lat_reg  <= lat_sat;
            wpos_reg <= HIDX_W'(head_reg);
            wcnt_reg <= '0;
            wv_reg   <= 1'b0;
            cl_reg   <= '0;
            ex_reg   <= '0;
        end
        if (cmd.win_rd)
        begin
            wpos_reg <= wpos_prev;
            wv_reg   <= 1'b1;
        end
        if (cmd.win_acc && wv_reg)
        begin
            wcnt_reg <= wcnt_reg + HCNT_W'(1);
            if (h_rdata >= cfg_thresh) ex_reg <= ex_reg + HCNT_W'(1);
            else cl_reg <= cl_reg + HCNT_W'(1);
        end
        if (cmd.finish)
        begin
            seq_out_reg <= (kind_reg == KIND_SEND) ? seq_in_reg : 32'd0;
            acc_reg     <= (kind_reg == KIND_RESP) && resp_ok_reg;
            lat_out_reg <= (kind_reg == KIND_COMPUTE) ? lat_reg : 24'd0;
            clr_out_reg <= (kind_reg == KIND_COMPUTE) ? 8'(cl_reg) : 8'd0;
            exc_out_reg <= (kind_reg == KIND_COMPUTE) ? 8'(ex_reg) : 8'd0;
        end
    end

    assign seq_out      = seq_out_reg;
    assign accepted     = acc_reg;
    assign overloaded   = ovl_reg;
    assign latency_ms   = lat_out_reg;
    assign clear_count  = clr_out_reg;
    assign exceed_count = exc_out_reg;
endmodule

@@ design/ping_latency_overload_monitor_unit.sv @@
// Top level of the ping latency overload monitor: APB registers, controller, datapath.
// Depends on plom_pkg, plom_if, plom_ctrl, plom_dp.
//
//  channel | direction | handshake        | payload
//  in_ch   | sink      | valid/ready      | kind, now_time, ping_time, ping_seq
//  out_ch  | source    | valid/ready      | result fields
//  apb     | slave     | psel/penable     | 6 registers at 4*i
//
// From accept to accept: a send or unused kind goes straight to the result; a response
// runs the 32-step divider, then, if accepted, a bucket read-modify-write. A compute
// scans the buckets in use, runs the mean division (skipped with an empty histogram),
// writes the history, reads the window and wraps the head one subtraction at a time.
// After the asynchronous reset a pass over all 128 entries clears both RAMs before input
// is taken. A new transaction is taken only once the result has been taken.
module ping_latency_overload_monitor_unit
    import plom_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plom_in_if.sink     in_ch,
    plom_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] width_reg;
    logic [7:0]  nbuck_reg;
    logic [23:0] thresh_reg;
    logic [7:0]  hlen_reg, clrwin_reg, excwin_reg;
    logic [2:0]  ridx;
    logic        wr_en;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 16'd50;
            nbuck_reg  <= 8'd100;
            thresh_reg <= 24'd500;
            hlen_reg   <= 8'd120;
            clrwin_reg <= 8'd24;
            excwin_reg <= 8'd4;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                REG_WIDTH:  width_reg  <= pwdata[15:0];
                REG_NBUCK:  nbuck_reg  <= pwdata[7:0];
                REG_THRESH: thresh_reg <= pwdata[23:0];
                REG_HLEN:   hlen_reg   <= pwdata[7:0];
                REG_CLRWIN: clrwin_reg <= pwdata[7:0];
                REG_EXCWIN: excwin_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (ridx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_NBUCK:  prdata = 32'(nbuck_reg);
            REG_THRESH: prdata = 32'(thresh_reg);
            REG_HLEN:   prdata = 32'(hlen_reg);
            REG_CLRWIN: prdata = 32'(clrwin_reg);
            REG_EXCWIN: prdata = 32'(excwin_reg);
            default:    prdata = 32'd0;
        endcase
    end

    plom_cmd_t  cmd;
    plom_stat_t stat;

    plom_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    plom_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .kind(in_ch.kind), .now_time(in_ch.now_time),
        .ping_time(in_ch.ping_time), .ping_seq(in_ch.ping_seq),
        .cfg_width(width_reg), .cfg_nbuck(nbuck_reg), .cfg_thresh(thresh_reg),
        .cfg_hlen(hlen_reg), .cfg_clrwin(clrwin_reg), .cfg_excwin(excwin_reg),
        .seq_out(out_ch.seq_out), .accepted(out_ch.accepted),
        .overloaded(out_ch.overloaded), .latency_ms(out_ch.latency_ms),
        .clear_count(out_ch.clear_count), .exceed_count(out_ch.exceed_count)
    );
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for ping_latency_overload_monitor_unit: directed and random
// transactions checked against a behavioral predictor. Depends on plom_pkg, plom_if.
module testbench;
    import plom_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_time;
        logic [31:0] ping_time;
        logic [31:0] ping_seq;
    } ping_item_t;

    typedef struct packed {
        logic [31:0] seq_out;
        logic        accepted;
        logic        overloaded;
        logic [23:0] latency_ms;
        logic [7:0]  clear_count;
        logic [7:0]  exceed_count;
    } load_result_t;

    localparam int STALL_LIMIT = 50000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    plom_in_if  in_ch();
    plom_out_if out_ch();

    ping_latency_overload_monitor_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of registers and state
    logic [15:0] width_reg;
    logic [7:0]  nbuck_reg;
    logic [23:0] thresh_reg;
    logic [7:0]  hlen_reg;
    logic [7:0]  clrwin_reg;
    logic [7:0]  excwin_reg;
    logic [31:0] bucket_cnt [NUM_BUCKETS];
    logic [23:0] lat_hist [HISTORY_DEPTH];
    int unsigned hist_head;
    logic        ovl_flag;
    logic [31:0] seq_next;
    logic [31:0] seq_start;

    load_result_t expected_results[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          hold_cnt;
    logic        hold_req;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned eff_buckets();
        if (nbuck_reg == 0) return 1;
        return (nbuck_reg > NUM_BUCKETS) ? NUM_BUCKETS : nbuck_reg;
    endfunction

    function automatic int unsigned eff_hlen();
        if (hlen_reg == 0) return 1;
        return (hlen_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : hlen_reg;
    endfunction

    function automatic int unsigned eff_width();
        return (width_reg == 0) ? 1 : width_reg;
    endfunction

    // Advance predictor state by one transaction and return its result
    function automatic load_result_t predict_load(ping_item_t it);
        load_result_t r;
        int unsigned  nb;
        int unsigned  len;
        int unsigned  b;
        int unsigned  w;
        int unsigned  pos;
        int unsigned  cl;
        int unsigned  ex;
        logic [63:0]  sum;
        logic [63:0]  entries;
        logic [63:0]  mean;
        logic [63:0]  lat;
        r = '0;
        nb = eff_buckets();
        len = eff_hlen();
        case (it.kind)
            KIND_SEND:
            begin
                r.seq_out = seq_next;
                seq_next = seq_next + 1;
            end
            KIND_RESP:
            begin
                if (it.now_time >= it.ping_time && it.ping_seq >= seq_start
                        && it.ping_seq < seq_next)
                begin
                    b = (it.now_time - it.ping_time) / eff_width();
                    if (b >= nb) b = nb - 1;
                    if (bucket_cnt[b] != 32'hFFFFFFFF) bucket_cnt[b] = bucket_cnt[b] + 1;
                    r.accepted = 1'b1;
                end
            end
            KIND_COMPUTE:
            begin
                sum = 0;
                entries = 0;
                for (int i = 0; i < nb; i++)
                begin
                    entries += bucket_cnt[i];
                    sum += 64'(bucket_cnt[i]) * 64'(i + 1);
                    bucket_cnt[i] = 0;
                end
                mean = (entries != 0) ? sum / entries : 64'd1;
                lat = mean * 64'(eff_width());
                if (lat > 64'(LAT_MAX)) lat = 64'(LAT_MAX);
                seq_start = seq_next;
                pos = hist_head % HISTORY_DEPTH;
                lat_hist[pos] = lat[23:0];
                hist_head = (hist_head + 1) % len;
                w = ovl_flag ? clrwin_reg : excwin_reg;
                if (w == 0 || w > len) w = len;
                cl = 0;
                ex = 0;
                for (int i = 0; i < w; i++)
                begin
                    if (lat_hist[pos] >= thresh_reg) ex++;
                    else cl++;
                    pos = (pos == 0) ? len - 1 : pos - 1;
                    if (pos >= HISTORY_DEPTH) pos = HISTORY_DEPTH - 1;
                end
                if (ovl_flag)
                begin
                    if (ex == 0) ovl_flag = 1'b0;
                end
                else if (ex != 0 && cl == 0)
                begin
                    ovl_flag = 1'b1;
                end
                r.latency_ms = lat[23:0];
                r.clear_count = (cl > 255) ? 8'd255 : cl[7:0];
                r.exceed_count = (ex > 255) ? 8'd255 : ex[7:0];
            end
            default:
            begin
            end
        endcase
        r.overloaded = ovl_flag;
        return r;
    endfunction

    // Send one transaction; sender works in bursts with random gaps
    task automatic send_item(input ping_item_t it);
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid = 1'b1;
        in_ch.kind = it.kind;
        in_ch.now_time = it.now_time;
        in_ch.ping_time = it.ping_time;
        in_ch.ping_seq = it.ping_seq;
        do @(posedge clk); while (!in_ch.ready);
        expected_results.push_back(predict_load(it));
        burst_left--;
    endtask

    task automatic send_kind(input logic [1:0] k, input logic [31:0] nt,
                             input logic [31:0] st, input logic [31:0] sq);
        ping_item_t it;
        it.kind = k;
        it.now_time = nt;
        it.ping_time = st;
        it.ping_seq = sq;
        send_item(it);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        burst_left = 0;
        wait (expected_results.size() == 0);
        repeat (5) @(negedge clk);
    endtask

    // Register write: setup then access phase
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_WIDTH:  width_reg = value[15:0];
            REG_NBUCK:  nbuck_reg = value[7:0];
            REG_THRESH: thresh_reg = value[23:0];
            REG_HLEN:   hlen_reg = value[7:0];
            REG_CLRWIN: clrwin_reg = value[7:0];
            default:    excwin_reg = value[7:0];
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] wd, input logic [31:0] nb,
                             input logic [31:0] th, input logic [31:0] hl,
                             input logic [31:0] cw, input logic [31:0] ew);
        drain();
        write_reg(REG_WIDTH, wd);
        write_reg(REG_NBUCK, nb);
        write_reg(REG_THRESH, th);
        write_reg(REG_HLEN, hl);
        write_reg(REG_CLRWIN, cw);
        write_reg(REG_EXCWIN, ew);
    endtask

    // A response for a ping from the open range, with latency lat
    task automatic send_good_resp(input logic [31:0] lat);
        logic [31:0] st;
        logic [31:0] span;
        if (seq_next == seq_start) send_kind(KIND_SEND, '0, '0, '0);
        st = $urandom;
        if (st > 32'hFFFFFFFF - lat) st = 32'hFFFFFFFF - lat;
        span = seq_next - seq_start;
        send_kind(KIND_RESP, st + lat, st, seq_start + $urandom_range(0, span - 1));
    endtask

    // Directed: reset values, field extremes, every kind, rejected responses
    task automatic test_directed();
        send_kind(KIND_COMPUTE, '0, '0, '0);
        send_kind(KIND_RSVD, '1, '1, '1);
        send_kind(KIND_RESP, 32'd10, 32'd0, 32'd0);
        repeat (3) send_kind(KIND_SEND, '0, '0, '0);
        send_kind(KIND_RESP, 32'hFFFFFFFF, 32'd0, 32'd0);
        send_kind(KIND_RESP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd2);
        send_kind(KIND_RESP, 32'd5, 32'd6, 32'd1);
        send_kind(KIND_RESP, 32'd100, 32'd0, 32'd3);
        send_kind(KIND_RESP, 32'd100, 32'd0, 32'hFFFFFFFF);
        send_kind(KIND_RESP, 32'd120, 32'd0, 32'd1);
        send_kind(KIND_COMPUTE, '0, '0, '0);
        send_kind(KIND_RESP, 32'd120, 32'd0, 32'd1);
        send_kind(KIND_SEND, '0, '0, '0);
        send_kind(KIND_RESP, 32'd900, 32'd0, 32'd3);
        send_kind(KIND_COMPUTE, '0, '0, '0);
        send_kind(KIND_RSVD, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'h0F0F0F0F);
    endtask

    // Register extremes: zero and oversized values, full-scale width
    task automatic test_config_extremes();
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_kind(KIND_SEND, '0, '0, '0);
        send_good_resp(32'd7);
        send_kind(KIND_COMPUTE, '0, '0, '0);
        write_all(32'hFFFF, 32'hFF, 32'hFFFFFF, 32'hFF, 32'hFF, 32'hFF);
        send_good_resp(32'hFFFFFFFF);
        send_good_resp(32'd70000);
        send_kind(KIND_COMPUTE, '0, '0, '0);
        write_all(32'd1, 32'd128, 32'd3, 32'd128, 32'd128, 32'd1);
        send_good_resp(32'd200);
        send_kind(KIND_COMPUTE, '0, '0, '0);
        send_kind(KIND_COMPUTE, '0, '0, '0);
    endtask

    // One well-formed round: sends, responses, noise, compute
    task automatic run_round(input int unsigned lat_hi, inout int sent);
        int n;
        n = $urandom_range(1, 5);
        repeat (n) send_kind(KIND_SEND, $urandom, $urandom, $urandom);
        sent += n;
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 8) send_good_resp($urandom_range(0, lat_hi));
            else send_kind(2'($urandom_range(0, 3)), $urandom, $urandom,
                           ($urandom_range(0, 1) != 0) ? $urandom : seq_start - 1);
            sent++;
        end
        send_kind(KIND_COMPUTE, $urandom, $urandom, $urandom);
        sent++;
    endtask

    // Random phases with random settings, including a shrink of the history
    task automatic test_random();
        int sent;
        int unsigned wd;
        int unsigned nb;
        sent = 0;
        while (sent < 980)
        begin
            wd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
            nb = $urandom_range(0, 255);
            write_all(wd, nb, $urandom_range(0, (wd + 1) * 8),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(1, 12),
                      $urandom_range(0, 10), $urandom_range(0, 6));
            repeat ($urandom_range(8, 20))
                run_round(($urandom_range(0, 1) != 0) ? (wd + 1) * 16 : (wd + 1) * 2, sent);
        end
    endtask

    // Back pressure: long receiver hold while the sender keeps offering
    task automatic test_pressure();
        int dummy;
        dummy = 0;
        hold_req = 1'b1;
        repeat (6) run_round(200, dummy);
        drain();
        repeat (3) run_round(200, dummy);
    endtask

    // Receiver: own stall pattern, with a long hold on request
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt == 0)
        begin
            hold_cnt = 600;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ch.ready = 1'b0;
        end
        else
        begin
            out_ch.ready = ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        load_result_t got;
        load_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.seq_out = out_ch.seq_out;
            got.accepted = out_ch.accepted;
            got.overloaded = out_ch.overloaded;
            got.latency_ms = out_ch.latency_ms;
            got.clear_count = out_ch.clear_count;
            got.exceed_count = out_ch.exceed_count;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.seq_out !== want.seq_out || got.accepted !== want.accepted
                        || got.overloaded !== want.overloaded
                        || got.latency_ms !== want.latency_ms
                        || got.clear_count !== want.clear_count
                        || got.exceed_count !== want.exceed_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or register access
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = '0;
        in_ch.now_time = '0;
        in_ch.ping_time = '0;
        in_ch.ping_seq = '0;
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        width_reg = 16'd50;
        nbuck_reg = 8'd100;
        thresh_reg = 24'd500;
        hlen_reg = 8'd120;
        clrwin_reg = 8'd24;
        excwin_reg = 8'd4;
        foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
        foreach (lat_hist[i]) lat_hist[i] = '0;
        hist_head = 0;
        ovl_flag = 1'b0;
        seq_next = '0;
        seq_start = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_config_extremes();
        write_all(32'd10, 32'd16, 32'd60, 32'd8, 32'd3, 32'd2);
        test_pressure();
        test_random();

        drain();
        repeat (400) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
design/plom_pkg.sv
design/plom_if.sv
design/plom_ram.sv
design/plom_ctrl.sv
design/plom_dp.sv
design/ping_latency_overload_monitor_unit.sv
bench/testbench.sv
